### rtl/lathist_pkg.sv
package lathist_pkg;

	// Field widths of the item channels
	localparam int unsigned SAMPLE_W   = 48;
	localparam int unsigned BOUND_W    = 47;
	localparam int unsigned IDX_W      = 3;
	localparam int unsigned HIT_W      = 4;
	localparam int unsigned OUT_CNT_W  = 32;
	localparam int unsigned SUM_W      = 64;
	localparam int unsigned NUM_BOUNDS = 8;
	localparam int unsigned REG_IDX_W  = 3;

	// Defaults for the top-level parameters
	localparam int unsigned DEF_BUCKETS    = 8;
	localparam int unsigned DEF_COUNT_BITS = 32;

	// Item kinds
	localparam logic MODE_RECORD = 1'b0;
	localparam logic MODE_READ   = 1'b1;

	// Special bucket_hit codes
	localparam logic [HIT_W-1:0] HIT_OVERFLOW = 4'd8;
	localparam logic [HIT_W-1:0] HIT_NONE     = 4'd9;

	// Bucket bounds after reset, in ns
	localparam logic [BOUND_W-1:0] BOUND_RESET [NUM_BOUNDS] = '{
		47'd1000, 47'd2000, 47'd5000, 47'd10000,
		47'd20000, 47'd50000, 47'd100000, 47'd1000000
	};

endpackage

### rtl/lathist_ram.sv
module lathist_ram
	import lathist_pkg::*;
#(
	parameter int unsigned WIDTH = DEF_COUNT_BITS,
	parameter int unsigned DEPTH = DEF_BUCKETS,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, two registered read ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

### rtl/latency_histogram.sv
// Channel   | Handshake            | Payload
// ----------+----------------------+-----------------------------------------------
// request   | req_valid, req_stall | mode, sample, bucket_index
// response  | rsp_valid, rsp_stall | bucket_hit, sample_dropped, bucket_count,
//           |                      | overflow_total, sample_total, latency_sum,
//           |                      | min_latency, max_latency, is_empty
// config    | cfg_we               | cfg_index, cfg_data
//
// One item per clock unless stalled; a response is registered after stage 1.
// The bucket counters live in a RAM read at the accept edge and written back as the
// item leaves stage 1; a write and a read of the same bucket at one edge are forwarded.
// Reset clears all counters at once through per-bucket valid bits; no sweep is needed.
// A stalled response holds the pipeline; a request is taken whenever the stage
// behind the RAM is free or moving on.
module latency_histogram
	import lathist_pkg::*;
#(
	parameter int unsigned BUCKETS    = DEF_BUCKETS,
	parameter int unsigned COUNT_BITS = DEF_COUNT_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [BOUND_W-1:0]   cfg_data,
	// request
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic                 mode,
	input  logic [SAMPLE_W-1:0]  sample,
	input  logic [IDX_W-1:0]     bucket_index,
	// response
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic [HIT_W-1:0]     bucket_hit,
	output logic                 sample_dropped,
	output logic [OUT_CNT_W-1:0] bucket_count,
	output logic [OUT_CNT_W-1:0] overflow_total,
	output logic [OUT_CNT_W-1:0] sample_total,
	output logic [SUM_W-1:0]     latency_sum,
	output logic [BOUND_W-1:0]   min_latency,
	output logic [BOUND_W-1:0]   max_latency,
	output logic                 is_empty
);

	localparam int unsigned AW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int unsigned EXT_W = (COUNT_BITS > OUT_CNT_W) ? COUNT_BITS : OUT_CNT_W;

	// Configuration registers
	logic [BOUND_W-1:0] bound_q [NUM_BOUNDS];

	// Scalar statistics
	logic [COUNT_BITS-1:0] ovf_cnt_q;
	logic [COUNT_BITS-1:0] acc_cnt_q;
	logic [SUM_W-1:0]      sum_q;
	logic [BOUND_W-1:0]    min_q;
	logic [BOUND_W-1:0]    max_q;

	// Bucket valid bits (entry not yet written reads as zero)
	logic [BUCKETS-1:0] vld_q;

	// Stage 1 (RAM data available)
	logic                  v_s1;
	logic                  upd_s1;
	logic [HIT_W-1:0]      hit_s1;
	logic                  drop_s1;
	logic                  in_b_s1;
	logic [AW-1:0]         addr_a_s1;
	logic [AW-1:0]         addr_b_s1;
	logic                  vld_a_s1;
	logic                  vld_b_s1;
	logic                  fwd_a_s1;
	logic                  fwd_b_s1;
	logic [COUNT_BITS-1:0] fwd_data_s1;

	// Accept-side logic
	logic                  accept;
	logic                  adv;
	logic                  neg;
	logic [BOUND_W-1:0]    smp;
	logic                  rec;
	logic [HIT_W-1:0]      hit;
	logic                  hit_bucket;
	logic [AW-1:0]         addr_a;
	logic [AW-1:0]         addr_b;
	logic                  in_b;
	logic [SUM_W:0]        sum_wide;

	// RAM ports
	logic                  wr_en;
	logic [COUNT_BITS-1:0] rd_a;
	logic [COUNT_BITS-1:0] rd_b;
	logic [COUNT_BITS-1:0] cnt_a;
	logic [COUNT_BITS-1:0] cnt_a_new;
	logic [COUNT_BITS-1:0] cnt_b;
	logic [COUNT_BITS-1:0] cnt_rep;

	logic [EXT_W-1:0] rep_ext;
	logic [EXT_W-1:0] ovf_ext;
	logic [EXT_W-1:0] acc_ext;

	// Handshake: stage 1 moves on when the response register is free or taken
	assign adv       = !rsp_valid || !rsp_stall;
	assign req_stall = v_s1 && !adv;
	assign accept    = req_valid && !req_stall;

	// Decode the incoming item
	assign neg = sample[SAMPLE_W-1];
	assign smp = sample[BOUND_W-1:0];
	assign rec = (mode == MODE_RECORD) && !neg;

	// First bucket whose bound covers the sample
	always_comb begin
		hit = HIT_OVERFLOW;
		for (int i = NUM_BOUNDS - 1; i >= 0; i--) begin
			if (i < BUCKETS && bound_q[i] >= smp) begin
				hit = HIT_W'(i);
			end
		end
	end

	assign hit_bucket = (hit != HIT_OVERFLOW);
	assign addr_a     = hit[AW-1:0];
	assign in_b       = (32'(bucket_index) < BUCKETS);
	assign addr_b     = bucket_index[AW-1:0];
	assign sum_wide   = {1'b0, sum_q} + (SUM_W + 1)'(smp);

	// Write the bound registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BOUNDS; i++) begin
				bound_q[i] <= BOUND_RESET[i];
			end
		end else if (cfg_we) begin
			bound_q[cfg_index] <= cfg_data;
		end
	end

	// Update the scalar statistics as a non-negative record sample is accepted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_cnt_q <= '0;
			acc_cnt_q <= '0;
			sum_q     <= '0;
			min_q     <= '0;
			max_q     <= '0;
		end else if (accept && rec) begin
			if (acc_cnt_q == '0) begin
				min_q <= smp;
				max_q <= smp;
			end else begin
				if (smp < min_q) min_q <= smp;
				if (smp > max_q) max_q <= smp;
			end
			if (!(&acc_cnt_q)) acc_cnt_q <= acc_cnt_q + 1'b1;
			sum_q <= sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
			if (!hit_bucket && !(&ovf_cnt_q)) ovf_cnt_q <= ovf_cnt_q + 1'b1;
		end
	end

	// Bucket counter store
	lathist_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (BUCKETS)
	) u_ram (
		.clk     (clk),
		.we      (wr_en),
		.waddr   (addr_a_s1),
		.wdata   (cnt_a_new),
		.re      (accept),
		.raddr_a (addr_a),
		.raddr_b (addr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// Resolve read data: forward the write made at the read edge, mask unwritten entries
	always_comb begin
		cnt_a     = fwd_a_s1 ? fwd_data_s1 : (vld_a_s1 ? rd_a : '0);
		cnt_b     = fwd_b_s1 ? fwd_data_s1 : (vld_b_s1 ? rd_b : '0);
		cnt_a_new = (&cnt_a) ? cnt_a : cnt_a + 1'b1;
		if (!in_b_s1) begin
			cnt_rep = '0;
		end else if (upd_s1 && addr_b_s1 == addr_a_s1) begin
			cnt_rep = cnt_a_new;
		end else begin
			cnt_rep = cnt_b;
		end
	end

	assign wr_en = v_s1 && adv && upd_s1;

	// Set valid bits as buckets are written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[addr_a_s1] <= 1'b1;
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	// Stage 1 payload, loaded with each accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			upd_s1      <= rec && hit_bucket;
			hit_s1      <= rec ? hit : HIT_NONE;
			drop_s1     <= (mode == MODE_RECORD) && neg;
			in_b_s1     <= in_b;
			addr_a_s1   <= addr_a;
			addr_b_s1   <= addr_b;
			vld_a_s1    <= vld_q[addr_a];
			vld_b_s1    <= vld_q[addr_b];
			fwd_a_s1    <= wr_en && (addr_a_s1 == addr_a);
			fwd_b_s1    <= wr_en && (addr_a_s1 == addr_b);
			fwd_data_s1 <= cnt_a_new;
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (adv) begin
			rsp_valid <= v_s1;
		end
	end

	assign rep_ext = EXT_W'(cnt_rep);
	assign ovf_ext = EXT_W'(ovf_cnt_q);
	assign acc_ext = EXT_W'(acc_cnt_q);

	// Capture the statistics after this item's update
	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			bucket_hit     <= hit_s1;
			sample_dropped <= drop_s1;
			bucket_count   <= rep_ext[OUT_CNT_W-1:0];
			overflow_total <= ovf_ext[OUT_CNT_W-1:0];
			sample_total   <= acc_ext[OUT_CNT_W-1:0];
			latency_sum    <= sum_q;
			min_latency    <= min_q;
			max_latency    <= max_q;
			is_empty       <= (acc_cnt_q == '0);
		end
	end

	// Checks
	a_wr_only_on_move: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> v_s1 && adv && hit_s1 != HIT_NONE && hit_s1 != HIT_OVERFLOW)
		else $error("bucket write without a record item leaving stage 1");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !is_empty |-> min_latency <= max_latency)
		else $error("minimum latency above maximum");

	a_drop_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && sample_dropped |-> bucket_hit == HIT_NONE)
		else $error("dropped item reports a bucket");

	a_read_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		accept && mode == MODE_READ |=> $stable(acc_cnt_q) && $stable(sum_q))
		else $error("read item changed the statistics");

endmodule
